[design/wtc_pkg.sv]
// shared constants for the wall texture column sampler
package wtc_pkg;

  // opcodes of an input transaction
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_POS_X    = 2'd0;
  localparam logic [1:0] REG_POS_Y    = 2'd1;
  localparam logic [1:0] REG_SCREEN_H = 2'd2;

  // fixed widths
  localparam int FRAC_W    = 16;
  localparam int LH_W      = 16;
  localparam int ROW_W     = 11;
  localparam int SIDE_W    = 2;
  localparam int SLOT_BITS = 12;
  localparam int TEX_COUNT = 4;
  localparam int ADDR_W    = SIDE_W + SLOT_BITS;
  localparam int MEM_DEPTH = TEX_COUNT << SLOT_BITS;

  localparam logic [ROW_W-1:0] SCREEN_H_RESET = 11'd480;

endpackage

[design/wtc_div.sv]
// restoring divider, one quotient bit per cycle
module wtc_div import wtc_pkg::*; #(
  parameter int DVD_W = 23
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [DVD_W-1:0] dividend,
  input  logic [LH_W-1:0]  divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [LH_W-1:0]  rem_r, rem_nxt;
  logic [LH_W:0]    trial;
  logic [LH_W:0]    diff;
  logic             ge;

  // one trial subtraction
  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign ge    = (trial >= {1'b0, divisor});
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    if (go) begin
      cnt_nxt = CNT_W'(DVD_W);
      dvd_nxt = dividend;
      rem_nxt = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
      dvd_nxt  = {dvd_r[DVD_W-2:0], ge};
      rem_nxt  = ge ? diff[LH_W-1:0] : trial[LH_W-1:0];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

[design/wall_texture_column_sampler.sv]
// Wall texture column sampler: texel store, column setup and per-pixel sampling.
//
// Input transactions are taken when start is high and busy is low. The opcode
// picks the work: a texel load writes one word of the texel memory (four
// textures of 4096 words each); a pixel tick reads the texel memory, and
// while busy is low, ticks and loads may come every cycle.
// A column start finds the texture column from the wall hit, runs the step
// division and forms the starting texture position; busy stays high through
// the hit, column, divide and position steps, with the restoring divider
// producing one quotient bit per cycle.
// A productive tick puts its pixel on the out_ ports with out_valid high for
// exactly one cycle, the cycle after the tick was accepted (the texel memory
// read latency). Ticks past the end of the column give no result. The
// receiver cannot stall; results are never held back. Configuration writes
// (cfg_valid with cfg_ready, always high) set the player position and screen
// height. The user must make them while the block is idle; it is not checked.
// Reset (rst_n low, synchronous) clears the column state and position registers;
// the texel memory is not cleared and must be loaded before it is sampled.
module wall_texture_column_sampler import wtc_pkg::*; #(
  parameter int TEXTURE_WIDTH  = 64,
  parameter int TEXTURE_HEIGHT = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // input channel
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              in_opcode,
  input  logic [SIDE_W-1:0]       in_wall_side,
  input  logic [SLOT_BITS-1:0]    in_texel_index,
  input  logic [31:0]             in_texel_color,
  input  logic [ROW_W-1:0]        in_screen_column,
  input  logic signed [31:0]      in_ray_dir_x,
  input  logic signed [31:0]      in_ray_dir_y,
  input  logic [31:0]             in_wall_distance,
  input  logic [LH_W-1:0]         in_wall_line_height,
  input  logic [ROW_W-1:0]        in_first_row,
  input  logic [ROW_W-1:0]        in_end_row,
  // result channel
  output logic                    out_valid,
  output logic [ROW_W-1:0]        out_pixel_row,
  output logic [ROW_W-1:0]        out_pixel_column,
  output logic [31:0]             out_pixel_color,
  output logic                    out_last_pixel,
  // configuration channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [31:0]             cfg_data
);

  localparam int CW    = $clog2(TEXTURE_WIDTH);
  localparam int CP_W  = FRAC_W + $clog2(TEXTURE_WIDTH + 1);
  localparam int DVD_W = $clog2(TEXTURE_HEIGHT + 1) + FRAC_W;
  localparam logic [DVD_W-1:0] DIVIDEND = DVD_W'(TEXTURE_HEIGHT) << FRAC_W;

  // sequencer codes
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_HIT  = 3'd1;
  localparam logic [2:0] ST_COL  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_POS  = 3'd4;

  logic [2:0]        state_r, state_nxt;

  // configuration registers
  logic [31:0]       pos_x_r, pos_y_r;
  logic [ROW_W-1:0]  screen_h_r;

  // column state
  logic [CW-1:0]     tex_col_r, tex_col_nxt;
  logic [31:0]       step_r, step_nxt;
  logic [31:0]       tpos_r, tpos_nxt;
  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic [ROW_W-1:0]  stop_row_r, stop_row_nxt;
  logic [ROW_W-1:0]  act_col_r, act_col_nxt;
  logic [SIDE_W-1:0] act_side_r, act_side_nxt;

  // column setup operands
  logic [31:0]       dist_r, dir_r, mul_r;
  logic [FRAC_W-1:0] posl_r;
  logic [LH_W-1:0]   lh_r;

  // result registers
  logic              out_valid_r;
  logic [ROW_W-1:0]  out_row_r, out_col_r;
  logic              out_last_r;
  logic [31:0]       rd_data_r;

  logic [31:0]       tex_mem [MEM_DEPTH];

  logic              accept, do_load, do_start, do_tick;
  logic [31:0]       mul_a, mul_b, mul_p;
  logic [FRAC_W-1:0] frac;
  logic [CP_W-1:0]   col_prod;
  logic [CW-1:0]     col_raw;
  logic [31:0]       base;
  logic [FRAC_W-1:0] trow;
  logic [SLOT_BITS-1:0] row_off, slot;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic              div_go, div_done;
  logic [DVD_W-1:0]  div_q;

  // transaction decode
  assign accept   = start && !busy;
  assign do_load  = accept && (in_opcode == OP_LOAD);
  assign do_start = accept && (in_opcode == OP_START);
  assign do_tick  = accept && (in_opcode == OP_TICK) && (cur_row_r < stop_row_r);

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // shared 32x32 multiplier, low half kept
  always_comb begin
    mul_a = dist_r;
    mul_b = dir_r;
    if (state_r == ST_POS) begin
      mul_a = base;
      mul_b = step_r;
    end
  end
  assign mul_p = mul_a * mul_b;

  // fractional hit and texture column
  assign frac     = posl_r + mul_r[31:FRAC_W];
  assign col_prod = CP_W'(frac) * CP_W'(TEXTURE_WIDTH);
  assign col_raw  = col_prod[FRAC_W +: CW];

  // start base row relative to screen center
  assign base = 32'(cur_row_r) - 32'(screen_h_r[ROW_W-1:1]) + 32'(lh_r[LH_W-1:1]);

  // texel address of the current pixel
  assign trow    = tpos_r[31:FRAC_W] & FRAC_W'(TEXTURE_HEIGHT - 1);
  assign row_off = trow[SLOT_BITS-1:0] * SLOT_BITS'(TEXTURE_WIDTH);
  assign slot    = row_off + SLOT_BITS'(tex_col_r);
  assign rd_addr = {act_side_r, slot};
  assign wr_addr = {in_wall_side, in_texel_index};

  assign div_go = (state_r == ST_COL);

  wtc_div #(
    .DVD_W (DVD_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (DIVIDEND),
    .divisor  (lh_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // sequencer and column state update
  always_comb begin
    state_nxt    = state_r;
    tex_col_nxt  = tex_col_r;
    step_nxt     = step_r;
    tpos_nxt     = tpos_r;
    cur_row_nxt  = cur_row_r;
    stop_row_nxt = stop_row_r;
    act_col_nxt  = act_col_r;
    act_side_nxt = act_side_r;
    case (state_r)
      ST_IDLE: begin
        if (do_start) begin
          state_nxt    = ST_HIT;
          act_side_nxt = in_wall_side;
          act_col_nxt  = in_screen_column;
          cur_row_nxt  = in_first_row;
          stop_row_nxt = in_end_row;
        end else if (do_tick) begin
          tpos_nxt    = tpos_r + step_r;
          cur_row_nxt = cur_row_r + 1'b1;
        end
      end
      ST_HIT: begin
        state_nxt = ST_COL;
      end
      ST_COL: begin
        state_nxt = ST_DIV;
        if (act_side_r == 2'd1 || act_side_r == 2'd2) begin
          tex_col_nxt = CW'(TEXTURE_WIDTH - 1) - col_raw;
        end else begin
          tex_col_nxt = col_raw;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_POS;
          step_nxt  = 32'(div_q);
        end
      end
      ST_POS: begin
        state_nxt = ST_IDLE;
        tpos_nxt  = mul_p;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control and column state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tex_col_r   <= '0;
      step_r      <= '0;
      tpos_r      <= '0;
      cur_row_r   <= '0;
      stop_row_r  <= '0;
      act_col_r   <= '0;
      act_side_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tex_col_r   <= tex_col_nxt;
      step_r      <= step_nxt;
      tpos_r      <= tpos_nxt;
      cur_row_r   <= cur_row_nxt;
      stop_row_r  <= stop_row_nxt;
      act_col_r   <= act_col_nxt;
      act_side_r  <= act_side_nxt;
      out_valid_r <= do_tick;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r    <= '0;
      pos_y_r    <= '0;
      screen_h_r <= SCREEN_H_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_POS_X:    pos_x_r    <= cfg_data;
        REG_POS_Y:    pos_y_r    <= cfg_data;
        REG_SCREEN_H: screen_h_r <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // setup operands, no reset needed
  always_ff @(posedge clk) begin
    if (do_start) begin
      dist_r <= in_wall_distance;
      lh_r   <= (in_wall_line_height == '0) ? LH_W'(1) : in_wall_line_height;
      if (in_wall_side <= 2'd1) begin
        dir_r  <= $unsigned(in_ray_dir_y);
        posl_r <= pos_y_r[FRAC_W-1:0];
      end else begin
        dir_r  <= $unsigned(in_ray_dir_x);
        posl_r <= pos_x_r[FRAC_W-1:0];
      end
    end
    if (state_r == ST_HIT) begin
      mul_r <= mul_p;
    end
  end

  // pixel result payload
  always_ff @(posedge clk) begin
    if (do_tick) begin
      out_row_r  <= cur_row_r;
      out_col_r  <= act_col_r;
      out_last_r <= ((cur_row_r + 1'b1) == stop_row_r);
    end
  end

  // texel memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (do_load) begin
      tex_mem[wr_addr] <= in_texel_color;
    end
    if (do_tick) begin
      rd_data_r <= tex_mem[rd_addr];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_row    = out_row_r;
  assign out_pixel_column = out_col_r;
  assign out_pixel_color  = rd_data_r;
  assign out_last_pixel   = out_last_r;

`ifndef SYNTHESIS
  // a result only follows an accepted tick
  a_out_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_opcode == OP_TICK))
    else $error("result without a tick transaction");

  // the last pixel leaves the column exhausted
  a_last_ends_column: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_pixel) |-> (cur_row_r == stop_row_r))
    else $error("last pixel flagged while rows remain");

  // the divider finishes only while the sequencer waits on it
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider done outside the divide step");
`endif

endmodule
